// ===== hw/rtl/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Shared constants, types and state encoding.
// ----------------------------------------------------------------------------
package srtf_pkg;
  localparam int MAX_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam int FW            = 16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN,
    ST_IO,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [FW-1:0] tick_time;
    logic          ran_valid;
    logic [3:0]    ran_slot;
    logic          finished;
    logic [FW-1:0] finish_time;
    logic [FW-1:0] turnaround;
    logic [FW-1:0] waiting;
    logic [FW-1:0] response;
    logic          all_done;
  } result_t;

  typedef struct packed {
    logic          kind;
    logic [3:0]    slot;
    logic [FW-1:0] arrival;
    logic [FW-1:0] total_need;
    logic [FW-1:0] run_interval;
    logic [FW-1:0] io_length;
  } item_t;
endpackage

// ===== hw/rtl/srtf_if.sv =====
// ----------------------------------------------------------------------------
// SRTF channel interfaces
// Valid/ready channels for input items, results and configuration.
// ----------------------------------------------------------------------------
interface srtf_in_if;
  logic            valid;
  logic            ready;
  srtf_pkg::item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srtf_out_if;
  logic              valid;
  logic              ready;
  srtf_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srtf_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] job_count;
  modport source (output valid, output job_count, input ready);
  modport sink (input valid, input job_count, output ready);
endinterface

// ===== hw/rtl/srtf_cmp.sv =====
// ----------------------------------------------------------------------------
// SRTF key compare
// Decides whether a candidate beats the current best (interval left, then
// arrival; lower slot wins by scan order).
// ----------------------------------------------------------------------------
module srtf_cmp #(
  parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
  input  logic                 have_best,
  input  logic [15:0]          cand_ivl,
  input  logic [TIME_BITS-1:0] cand_arr,
  input  logic [15:0]          best_ivl,
  input  logic [TIME_BITS-1:0] best_arr,
  output logic                 better
);
  always_comb begin
    better = !have_best || (cand_ivl < best_ivl) ||
             ((cand_ivl == best_ivl) && (cand_arr < best_arr));
  end
endmodule

// ===== hw/rtl/srtf_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// SRTF tick scheduler
// Shortest-remaining-time-first job scheduler advanced one tick per item.
// ----------------------------------------------------------------------------
// Load transaction: no result.
// Tick transaction: SCAN, RUN and IO states, then the result is offered in OUT;
//   SCAN visits one slot per scan cycle through the shared compare unit.
// One item at a time; in.ready is low until the result is taken.
// Reset (rst, synchronous): ready flags, FIFO, time and counts clear;
//   job_count = 1. Job tables are undefined until loaded.
module srtf_tick_scheduler #(
  parameter int MAX_JOBS  = srtf_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  srtf_in_if.sink        in,
  srtf_out_if.source     out,
  srtf_cfg_if.sink       cfg
);
  localparam int SW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int FW = srtf_pkg::FW;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [TIME_BITS-1:0] arr_t [MAX_JOBS];
  logic [FW-1:0]        need_t [MAX_JOBS];
  logic [FW-1:0]        left_t [MAX_JOBS];
  logic [FW-1:0]        ivl_left_t [MAX_JOBS];
  logic [FW-1:0]        ivl_t [MAX_JOBS];
  logic [FW-1:0]        iol_t [MAX_JOBS];
  logic [FW-1:0]        io_left_t [MAX_JOBS];
  logic [TIME_BITS-1:0] first_t [MAX_JOBS];
  logic [MAX_JOBS-1:0]  ready_flags;
  logic [SW-1:0]        fifo [MAX_JOBS];
  logic [SW-1:0]        head;
  logic [CW-1:0]        fcount;
  logic [TIME_BITS-1:0] now;
  logic                 held;
  logic [4:0]           done_count;
  logic [4:0]           job_count;

  srtf_pkg::state_t     state, state_next;
  logic [SW-1:0]        idx;
  logic                 found;
  logic [SW-1:0]        best;
  logic [FW-1:0]        best_ivl;
  logic [TIME_BITS-1:0] best_arr;
  srtf_pkg::result_t    res;
  logic                 better;

  logic [4:0] n_lim;
  logic       arrive;
  logic       is_ready;
  logic       idx_last;
  logic       fin_now;

  assign n_lim = (32'(job_count) < MAX_JOBS) ? job_count : 5'(MAX_JOBS);
  assign arrive = !held && (32'(idx) < 32'(n_lim)) && (arr_t[idx] == now);
  assign is_ready = ready_flags[idx] || arrive;
  assign idx_last = (32'(idx) == MAX_JOBS - 1);

  srtf_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
    .have_best (found),
    .cand_ivl  (ivl_left_t[idx]),
    .cand_arr  (arr_t[idx]),
    .best_ivl  (best_ivl),
    .best_arr  (best_arr),
    .better    (better)
  );

  assign cfg.ready = (state == srtf_pkg::ST_IDLE);
  assign in.ready  = (state == srtf_pkg::ST_IDLE);
  assign out.valid = (state == srtf_pkg::ST_OUT);
  assign out.payload = res;

  always_comb begin
    state_next = state;
    unique case (state)
      srtf_pkg::ST_IDLE: begin
        if (in.valid && in.payload.kind == srtf_pkg::KIND_TICK) state_next = srtf_pkg::ST_SCAN;
      end
      srtf_pkg::ST_SCAN: begin
        if (idx_last) state_next = srtf_pkg::ST_RUN;
      end
      srtf_pkg::ST_RUN: state_next = srtf_pkg::ST_IO;
      srtf_pkg::ST_IO:  state_next = srtf_pkg::ST_OUT;
      srtf_pkg::ST_OUT: begin
        if (out.ready) state_next = srtf_pkg::ST_IDLE;
      end
      default: state_next = srtf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= srtf_pkg::ST_IDLE;
    else state <= state_next;
  end

  // tables
  logic [FW-1:0] l1, v1;
  logic [SW-1:0] hs;
  logic [FW-1:0] io1;
  always_comb begin
    l1  = (left_t[best] != '0) ? left_t[best] - 1'b1 : '0;
    v1  = (ivl_left_t[best] != '0) ? ivl_left_t[best] - 1'b1 : '0;
    hs  = fifo[head];
    io1 = (io_left_t[hs] != '0) ? io_left_t[hs] - 1'b1 : '0;
  end

  assign fin_now = found && (l1 == '0);

  // first run is this tick when nothing has run yet
  logic [TIME_BITS-1:0] fin_t, turn_t, wait_t, resp_t, first_v;
  always_comb begin
    first_v = (left_t[best] == need_t[best]) ? now : first_t[best];
    fin_t  = (now < TMAX) ? now + 1'b1 : TMAX;
    turn_t = (fin_t > arr_t[best]) ? fin_t - arr_t[best] : '0;
    wait_t = (turn_t > TIME_BITS'(need_t[best])) ? turn_t - TIME_BITS'(need_t[best]) : '0;
    resp_t = (first_v > arr_t[best]) ? first_v - arr_t[best] : '0;
  end

  always_ff @(posedge clk) begin
    if (state == srtf_pkg::ST_IDLE && in.valid && in.payload.kind == srtf_pkg::KIND_LOAD &&
        32'(in.payload.slot) < MAX_JOBS) begin
      arr_t[SW'(in.payload.slot)]      <= TIME_BITS'(in.payload.arrival);
      need_t[SW'(in.payload.slot)]     <= in.payload.total_need;
      left_t[SW'(in.payload.slot)]     <= in.payload.total_need;
      ivl_t[SW'(in.payload.slot)]      <= in.payload.run_interval;
      ivl_left_t[SW'(in.payload.slot)] <= in.payload.run_interval;
      iol_t[SW'(in.payload.slot)]      <= in.payload.io_length;
      io_left_t[SW'(in.payload.slot)]  <= '0;
    end else if (state == srtf_pkg::ST_RUN && found) begin
      if (left_t[best] == need_t[best]) first_t[best] <= now;
      left_t[best] <= l1;
      if (l1 != '0 && v1 == '0) begin
        ivl_left_t[best] <= ivl_t[best];
        io_left_t[best]  <= iol_t[best];
        if (32'(fcount) < MAX_JOBS) fifo[SW'(32'(head) + 32'(fcount))] <= best;
      end else begin
        ivl_left_t[best] <= v1;
      end
    end else if (state == srtf_pkg::ST_IO && fcount != '0) begin
      io_left_t[hs] <= io1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flags <= '0;
      head        <= '0;
      fcount      <= '0;
      now         <= '0;
      held        <= 1'b0;
      done_count  <= '0;
      job_count   <= 5'd1;
      idx         <= '0;
      found       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) job_count <= cfg.job_count;
      unique case (state)
        srtf_pkg::ST_IDLE: begin
          idx   <= '0;
          found <= 1'b0;
        end
        srtf_pkg::ST_SCAN: begin
          if (arrive) ready_flags[idx] <= 1'b1;
          if (is_ready && better) begin
            found    <= 1'b1;
            best     <= idx;
            best_ivl <= ivl_left_t[idx];
            best_arr <= arr_t[idx];
          end
          idx <= idx + 1'b1;
        end
        srtf_pkg::ST_RUN: begin
          res.tick_time   <= FW'(now);
          res.ran_valid   <= found;
          res.ran_slot    <= found ? 4'(best) : 4'd0;
          res.finished    <= fin_now;
          res.finish_time <= fin_now ? FW'(fin_t) : '0;
          res.turnaround  <= fin_now ? FW'(turn_t) : '0;
          res.waiting     <= fin_now ? FW'(wait_t) : '0;
          res.response    <= fin_now ? FW'(resp_t) : '0;
          if (fin_now) begin
            if (done_count != 5'd31) done_count <= done_count + 1'b1;
            ready_flags[best] <= 1'b0;
          end else if (found && v1 == '0) begin
            ready_flags[best] <= 1'b0;
            if (32'(fcount) < MAX_JOBS) fcount <= fcount + 1'b1;
          end
        end
        srtf_pkg::ST_IO: begin
          if (fcount != '0 && io1 == '0) begin
            head <= head + 1'b1;
            fcount <= fcount - 1'b1;
            ready_flags[hs] <= 1'b1;
          end
          if (now < TMAX) now <= now + 1'b1;
          else held <= 1'b1;
          res.all_done <= (done_count >= job_count);
        end
        srtf_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/srtf_checker.sv =====
// ----------------------------------------------------------------------------
// SRTF port checker
// Port-level properties of the scheduler, bound into srtf_tick_scheduler.
// ----------------------------------------------------------------------------
module srtf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input srtf_pkg::result_t res
);
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("input transaction withdrawn");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result dropped while stalled");
  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.finished |-> res.ran_valid) else $error("finish without run");
  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ran_valid |-> res.ran_slot == 4'd0) else $error("idle slot");
endmodule

bind srtf_tick_scheduler srtf_checker u_srtf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in.valid),
  .in_ready  (in.ready),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .res       (out.payload)
);

// ===== verif/srtf_tick_scheduler_checker.sv =====
// ----------------------------------------------------------------------------
// SRTF tick scheduler checker
// Watches the item, result and configuration channels, keeps its own copy
// of the job tables and queues, predicts each tick's report and compares it
// field by field with what the scheduler hands out.
// ----------------------------------------------------------------------------
module srtf_tick_scheduler_checker (
  input  logic clk,
  input  logic rst,
  srtf_in_if   in_ch,
  srtf_out_if  out_ch,
  srtf_cfg_if  cfg_ch,
  output int   fail_count,
  output int   reports_due
);
  localparam int SLOTS = srtf_pkg::MAX_JOBS_DEF;
  localparam int FW = srtf_pkg::FW;
  localparam logic [FW-1:0] T_MAX = '1;

  logic [FW-1:0] arrive_t [SLOTS];
  logic [FW-1:0] need_t   [SLOTS];
  logic [FW-1:0] left_t   [SLOTS];
  logic [FW-1:0] burst_t  [SLOTS];
  logic [FW-1:0] burst_left_t [SLOTS];
  logic [FW-1:0] io_len_t [SLOTS];
  logic [FW-1:0] io_left_t [SLOTS];
  logic [FW-1:0] first_t  [SLOTS];
  logic [SLOTS-1:0] ready_f;
  logic [3:0]    io_q [SLOTS];
  int            io_head, io_count;
  logic [FW-1:0] clock_now;
  bit            stuck;
  int            done_n;
  logic [4:0]    jobs;
  int            fails;
  srtf_pkg::result_t report_q[$];

  function automatic logic [FW-1:0] dec_sat(logic [FW-1:0] v);
    return (v != 0) ? v - 1'b1 : '0;
  endfunction

  task automatic report(string what, logic [FW-1:0] got, logic [FW-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic schedule_tick(output srtf_pkg::result_t r);
    int n, best, s, turn, fin, wait_t;
    bit found;
    r = '0;
    r.tick_time = clock_now;
    n = (int'(jobs) < SLOTS) ? int'(jobs) : SLOTS;
    if (!stuck)
      for (int i = 0; i < n; i++)
        if (arrive_t[i] == clock_now) ready_f[i] = 1'b1;
    found = 0;
    best = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!ready_f[i]) continue;
      if (!found || burst_left_t[i] < burst_left_t[best] ||
          (burst_left_t[i] == burst_left_t[best] && arrive_t[i] < arrive_t[best])) begin
        best = i;
        found = 1;
      end
    end
    if (found) begin
      r.ran_valid = 1'b1;
      r.ran_slot = best[3:0];
      ready_f[best] = 1'b0;
      if (left_t[best] == need_t[best]) first_t[best] = clock_now;
      left_t[best] = dec_sat(left_t[best]);
      burst_left_t[best] = dec_sat(burst_left_t[best]);
      if (left_t[best] == 0) begin
        fin = (clock_now < T_MAX) ? int'(clock_now) + 1 : int'(T_MAX);
        turn = (fin > int'(arrive_t[best])) ? fin - int'(arrive_t[best]) : 0;
        wait_t = (turn > int'(need_t[best])) ? turn - int'(need_t[best]) : 0;
        r.finished = 1'b1;
        r.finish_time = fin[FW-1:0];
        r.turnaround = turn[FW-1:0];
        r.waiting = wait_t[FW-1:0];
        r.response = (first_t[best] > arrive_t[best]) ? first_t[best] - arrive_t[best] : '0;
        if (done_n < 31) done_n++;
      end else if (burst_left_t[best] == 0) begin
        burst_left_t[best] = burst_t[best];
        io_left_t[best] = io_len_t[best];
        if (io_count < SLOTS) begin
          io_q[(io_head + io_count) % SLOTS] = best[3:0];
          io_count++;
        end
      end else begin
        ready_f[best] = 1'b1;
      end
    end
    if (io_count > 0) begin
      s = int'(io_q[io_head]);
      io_left_t[s] = dec_sat(io_left_t[s]);
      if (io_left_t[s] == 0) begin
        io_head = (io_head + 1) % SLOTS;
        io_count--;
        ready_f[s] = 1'b1;
      end
    end
    if (clock_now < T_MAX) clock_now++;
    else stuck = 1;
    r.all_done = (done_n >= int'(jobs));
  endtask

  always @(posedge clk) begin
    srtf_pkg::result_t got, want;
    srtf_pkg::item_t it;
    if (rst) begin
      ready_f = '0;
      io_head = 0;
      io_count = 0;
      clock_now = '0;
      stuck = 0;
      done_n = 0;
      jobs = 5'd1;
      fails = 0;
      report_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) jobs = cfg_ch.job_count;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (report_q.size() == 0) begin
          report("unexpected report", got.tick_time, '0);
        end else begin
          want = report_q.pop_front();
          if (got.tick_time !== want.tick_time) report("tick_time", got.tick_time, want.tick_time);
          if (got.ran_valid !== want.ran_valid) report("ran_valid", got.ran_valid, want.ran_valid);
          if (got.ran_slot !== want.ran_slot) report("ran_slot", got.ran_slot, want.ran_slot);
          if (got.finished !== want.finished) report("finished", got.finished, want.finished);
          if (got.finish_time !== want.finish_time)
            report("finish_time", got.finish_time, want.finish_time);
          if (got.turnaround !== want.turnaround)
            report("turnaround", got.turnaround, want.turnaround);
          if (got.waiting !== want.waiting) report("waiting", got.waiting, want.waiting);
          if (got.response !== want.response) report("response", got.response, want.response);
          if (got.all_done !== want.all_done) report("all_done", got.all_done, want.all_done);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it = in_ch.payload;
        if (it.kind == srtf_pkg::KIND_LOAD) begin
          arrive_t[it.slot] = it.arrival;
          need_t[it.slot] = it.total_need;
          left_t[it.slot] = it.total_need;
          burst_t[it.slot] = it.run_interval;
          burst_left_t[it.slot] = it.run_interval;
          io_len_t[it.slot] = it.io_length;
          io_left_t[it.slot] = '0;
        end else begin
          schedule_tick(want);
          report_q = {report_q, want};
        end
      end
    end
    fail_count <= fails;
    reports_due <= report_q.size();
  end
endmodule

// ===== verif/srtf_tick_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// SRTF tick scheduler testbench
// Loads job tables, sets the job count between phases and issues ticks with
// random gaps and back-pressure; the checker predicts and compares reports.
// ----------------------------------------------------------------------------
module srtf_tick_scheduler_tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int FW = srtf_pkg::FW;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, reports_due;
  int   hold_cycles;
  bit   hold_req = 1'b0;
  bit   hold_seen;
  int   ticks_sent = 0;
  longint cycles = 0;

  srtf_in_if  in_ch ();
  srtf_out_if out_ch ();
  srtf_cfg_if cfg_ch ();

  srtf_tick_scheduler dut (.clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch));

  srtf_tick_scheduler_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .reports_due(reports_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("srtf_tick_scheduler verification failed");
      $finish;
    end
  end

  // report receiver: random stalls, calm stretches, forced long hold-offs
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req != hold_seen) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= LONG_HOLD;
      hold_seen <= hold_req;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      if ((cycles / 200) % 4 == 1) stall = 0;
      out_ch.ready <= (stall == 0);
      hold_cycles <= stall;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 4) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  task automatic send(srtf_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (it.kind == srtf_pkg::KIND_TICK) ticks_sent++;
  endtask

  task automatic load_job(int s, int arr, int need, int burst, int io_len);
    srtf_pkg::item_t it;
    it = '0;
    it.kind = srtf_pkg::KIND_LOAD;
    it.slot = s[3:0];
    it.arrival = arr[FW-1:0];
    it.total_need = need[FW-1:0];
    it.run_interval = burst[FW-1:0];
    it.io_length = io_len[FW-1:0];
    send(it);
  endtask

  task automatic tick();
    srtf_pkg::item_t it;
    it = '0;
    it.kind = srtf_pkg::KIND_TICK;
    it.slot = 4'($urandom());
    it.arrival = FW'($urandom());
    send(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_jobs(int n);
    cfg_ch.valid <= 1'b1;
    cfg_ch.job_count <= n[4:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int rnd_field(int lo, int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return $urandom_range(0, 16'hFFFF);
    if (r == 2) return 0;
    return $urandom_range(lo, hi);
  endfunction

  initial begin
    int jc, nload, nticks;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.job_count = 5'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every slot defined, extremes of each field
    set_jobs(16);
    for (int s = 0; s < 16; s++)
      load_job(s, (s < 12) ? s % 4 : 16'hFFFF, (s == 1) ? 16'hFFFF : 1 + s % 3,
               (s == 2) ? 16'hFFFF : 1 + s % 2, (s == 3) ? 16'hFFFF : 2);
    load_job(3, 0, 4, 1, 16'hFFFF);
    repeat (6) tick();
    load_job(3, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      jc = (ph == 0) ? 1 : (ph == 1) ? 16 : $urandom_range(1, 16);
      set_jobs(jc);
      nload = $urandom_range(2, 8);
      nticks = $urandom_range(20, 38);
      for (int k = 0; k < nload; k++)
        load_job($urandom_range(0, 15),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16'hFFFF)
                                             : ticks_sent + $urandom_range(0, 15),
                 rnd_field(1, 12), rnd_field(1, 6), rnd_field(1, 8));
      if (ph == 5) hold_req <= ~hold_req;
      for (int k = 0; k < nticks; k++) begin
        if ($urandom_range(0, 7) == 0)
          load_job($urandom_range(0, 15), ticks_sent + $urandom_range(0, 6),
                   rnd_field(1, 10), rnd_field(1, 5), rnd_field(1, 6));
        tick();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("srtf_tick_scheduler verification clean");
    end else begin
      $display("srtf_tick_scheduler verification failed");
    end
    $finish;
  end
endmodule
